FILE: sv/ps2cre_pkg.sv
// ----------------------------------------------------------------------------
// ps2cre_pkg
// Types and codes shared by the PS/2 command/acknowledge retry engine.
// ----------------------------------------------------------------------------
package ps2cre_pkg;

	// Item operation codes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_WR_TO   = 2'd1;
	localparam logic [1:0] ERR_RD_TO   = 2'd2;
	localparam logic [1:0] ERR_ATTEMPT = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_ATTEMPT_LIMIT   = 2'd0;
	localparam logic [1:0] REG_UNRELATED_LIMIT = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd2;

	// Exchange phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_WR_PRE  = 3'd1;
	localparam logic [2:0] PH_WR_DATA = 3'd2;
	localparam logic [2:0] PH_RD      = 3'd3;
	localparam logic [2:0] PH_RD_AA   = 3'd4;

	// Protocol bytes
	localparam logic [7:0] BYTE_PREFIX_CH2 = 8'hD4;
	localparam logic [7:0] BYTE_SELF_TEST  = 8'hAA;
	localparam logic [7:0] BYTE_ACK        = 8'hFA;
	localparam logic [7:0] BYTE_ECHO       = 8'hEE;
	localparam logic [7:0] BYTE_RESEND     = 8'hFE;

	localparam logic [1:0] CHANNEL_TWO = 2'd2;

	typedef struct packed {
		logic [3:0] attempt_limit;
		logic [7:0] unrelated_limit;
		logic [9:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] channel;
		logic [7:0] command;
		logic [7:0] rx_byte;
		logic       inbuf_full;
	} item_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       target_channel;
		logic [7:0] pending_command;
		logic [3:0] attempt_count;
		logic [7:0] unrelated_count;
		logic [9:0] wait_count;
		logic [7:0] last_answer;
	} state_t;

	typedef struct packed {
		logic       write_valid;
		logic       write_to_cmd_port;
		logic [7:0] write_byte;
		logic       done_res;
		logic       success;
		logic [7:0] answer;
		logic [1:0] error_code;
	} result_t;

endpackage

FILE: sv/ps2cre_step.sv
// ----------------------------------------------------------------------------
// ps2cre_step
// Next-state and result logic for one item of the command retry engine.
// ----------------------------------------------------------------------------
module ps2cre_step (
	input  ps2cre_pkg::cfg_t    cfg,
	input  ps2cre_pkg::item_t   item,
	input  ps2cre_pkg::state_t  cur,
	output ps2cre_pkg::state_t  nxt,
	output logic                emit,
	output ps2cre_pkg::result_t res
);

	always_comb begin
		logic       do_judge;
		logic       do_resend;
		logic       do_begin;
		logic       do_write;
		logic       do_done;
		logic       ok;
		logic [1:0] err;

		nxt       = cur;
		res       = '0;
		emit      = 1'b0;
		do_judge  = 1'b0;
		do_resend = 1'b0;
		do_begin  = 1'b0;
		do_write  = 1'b0;
		do_done   = 1'b0;
		ok        = 1'b0;
		err       = ps2cre_pkg::ERR_NONE;

		case (item.operation)
			ps2cre_pkg::OP_START: begin
				if (cur.phase == ps2cre_pkg::PH_IDLE) begin
					nxt.target_channel  = (item.channel == ps2cre_pkg::CHANNEL_TWO);
					nxt.pending_command = item.command;
					nxt.attempt_count   = '0;
					nxt.unrelated_count = '0;
					nxt.last_answer     = '0;
					if (cfg.attempt_limit == '0) begin
						do_done = 1'b1;
						err     = ps2cre_pkg::ERR_ATTEMPT;
					end else begin
						do_begin = 1'b1;
					end
				end
			end
			ps2cre_pkg::OP_BYTE: begin
				if (cur.phase == ps2cre_pkg::PH_RD || cur.phase == ps2cre_pkg::PH_RD_AA) begin
					nxt.last_answer = item.rx_byte;
					if (cur.phase == ps2cre_pkg::PH_RD &&
					    item.rx_byte == ps2cre_pkg::BYTE_SELF_TEST) begin
						// skip one self-test pass byte
						nxt.phase      = ps2cre_pkg::PH_RD_AA;
						nxt.wait_count = '0;
					end else begin
						do_judge = 1'b1;
					end
				end
			end
			ps2cre_pkg::OP_TICK: begin
				if (cur.phase == ps2cre_pkg::PH_WR_PRE || cur.phase == ps2cre_pkg::PH_WR_DATA) begin
					nxt.wait_count = cur.wait_count + 10'd1;
					if (!item.inbuf_full) begin
						do_write = 1'b1;
					end else if (nxt.wait_count >= cfg.timeout_ticks) begin
						do_done = 1'b1;
						err     = ps2cre_pkg::ERR_WR_TO;
					end
				end else if (cur.phase == ps2cre_pkg::PH_RD ||
				             cur.phase == ps2cre_pkg::PH_RD_AA) begin
					nxt.wait_count = cur.wait_count + 10'd1;
					if (nxt.wait_count >= cfg.timeout_ticks) begin
						do_done = 1'b1;
						err     = ps2cre_pkg::ERR_RD_TO;
					end
				end
			end
			default: ;
		endcase

		// classify the reply byte
		if (do_judge) begin
			if (item.rx_byte == ps2cre_pkg::BYTE_ACK || item.rx_byte == ps2cre_pkg::BYTE_ECHO) begin
				do_done = 1'b1;
				ok      = 1'b1;
			end else if (item.rx_byte == ps2cre_pkg::BYTE_RESEND) begin
				do_resend = 1'b1;
			end else begin
				nxt.unrelated_count = cur.unrelated_count + 8'd1;
				if (nxt.unrelated_count == cfg.unrelated_limit) begin
					do_resend = 1'b1;
				end else begin
					nxt.phase      = ps2cre_pkg::PH_RD;
					nxt.wait_count = '0;
				end
			end
		end

		if (do_resend) begin
			nxt.attempt_count = nxt.attempt_count + 4'd1;
			if (nxt.attempt_count >= cfg.attempt_limit) begin
				do_done = 1'b1;
				err     = ps2cre_pkg::ERR_ATTEMPT;
			end else begin
				do_begin = 1'b1;
			end
		end

		if (do_begin) begin
			nxt.phase      = nxt.target_channel ? ps2cre_pkg::PH_WR_PRE : ps2cre_pkg::PH_WR_DATA;
			nxt.wait_count = '0;
			if (!item.inbuf_full) begin
				do_write = 1'b1;
			end else if (cfg.timeout_ticks == '0) begin
				do_done = 1'b1;
				err     = ps2cre_pkg::ERR_WR_TO;
			end
		end

		if (do_write) begin
			emit            = 1'b1;
			res.write_valid = 1'b1;
			res.answer      = nxt.last_answer;
			if (nxt.phase == ps2cre_pkg::PH_WR_PRE) begin
				res.write_to_cmd_port = 1'b1;
				res.write_byte        = ps2cre_pkg::BYTE_PREFIX_CH2;
				nxt.phase             = ps2cre_pkg::PH_WR_DATA;
			end else begin
				res.write_byte      = nxt.pending_command;
				nxt.phase           = ps2cre_pkg::PH_RD;
				nxt.unrelated_count = '0;
			end
			nxt.wait_count = '0;
		end else if (do_done) begin
			emit           = 1'b1;
			res.done_res   = 1'b1;
			res.success    = ok;
			res.answer     = nxt.last_answer;
			res.error_code = err;
			nxt.phase      = ps2cre_pkg::PH_IDLE;
			nxt.wait_count = '0;
		end
	end

endmodule

FILE: sv/ps2_device_command_retry_engine.sv
// An accepted item is held in the input register; its result, if any, is shown from the result register.
// Throughput: one item per cycle; each item passes the input register and the
// single-pass step logic once, with the result register as the only stall point.
// Reset (arst_n low, asynchronous): exchange idle, counters cleared, both
// registers empty, attempt_limit 5, unrelated_limit 100, timeout_ticks 100.
// ----------------------------------------------------------------------------
// ps2_device_command_retry_engine
// Host-side PS/2 command send with acknowledge wait, resend and timeouts.
// ----------------------------------------------------------------------------
module ps2_device_command_retry_engine (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data,
	// item channel
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] operation,
	input  logic [1:0] channel,
	input  logic [7:0] command,
	input  logic [7:0] rx_byte,
	input  logic       inbuf_full,
	// result channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic       write_valid,
	output logic       write_to_cmd_port,
	output logic [7:0] write_byte,
	output logic       done_res,
	output logic       success,
	output logic [7:0] answer,
	output logic [1:0] error_code
);

	ps2cre_pkg::cfg_t    cfg_q;
	ps2cre_pkg::state_t  state_q;
	ps2cre_pkg::state_t  state_nxt;
	ps2cre_pkg::item_t   item_s1;
	logic                valid_s1;
	ps2cre_pkg::result_t res_q;
	ps2cre_pkg::result_t res_nxt;
	logic                res_valid_q;
	logic                emit;
	logic                advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attempt_limit   <= 4'd5;
			cfg_q.unrelated_limit <= 8'd100;
			cfg_q.timeout_ticks   <= 10'd100;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ps2cre_pkg::REG_ATTEMPT_LIMIT:   cfg_q.attempt_limit   <= cfg_data[3:0];
				ps2cre_pkg::REG_UNRELATED_LIMIT: cfg_q.unrelated_limit <= cfg_data[7:0];
				ps2cre_pkg::REG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= cfg_data;
				default: ;
			endcase
		end
	end

	// the step stage moves whenever the result register is free or being drained
	assign advance    = !res_valid_q || !res_stall;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1.operation  <= operation;
			item_s1.channel    <= channel;
			item_s1.command    <= command;
			item_s1.rx_byte    <= rx_byte;
			item_s1.inbuf_full <= inbuf_full;
		end
	end

	ps2cre_step u_step (
		.cfg  (cfg_q),
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.emit (emit),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid         = res_valid_q;
	assign write_valid       = res_q.write_valid;
	assign write_to_cmd_port = res_q.write_to_cmd_port;
	assign write_byte        = res_q.write_byte;
	assign done_res          = res_q.done_res;
	assign success           = res_q.success;
	assign answer            = res_q.answer;
	assign error_code        = res_q.error_code;

endmodule

FILE: sv/ps2cre_chk.sv
// ----------------------------------------------------------------------------
// ps2cre_chk
// Port-level checks for the command retry engine, bound to the top level.
// ----------------------------------------------------------------------------
module ps2cre_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic       write_valid,
	input logic       write_to_cmd_port,
	input logic [7:0] write_byte,
	input logic       done_res,
	input logic       success,
	input logic [7:0] answer,
	input logic [1:0] error_code
);

	// a stalled result beat stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	// every beat is either a write or a finish, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (write_valid ^ done_res))
		else $error("result beat is not exactly one of write or done");

	a_success: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res && success |->
			error_code == ps2cre_pkg::ERR_NONE &&
			(answer == ps2cre_pkg::BYTE_ACK || answer == ps2cre_pkg::BYTE_ECHO))
		else $error("success without an acknowledge answer");

	a_failure: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res && !success |-> error_code != ps2cre_pkg::ERR_NONE)
		else $error("failed exchange without an error code");

	// command port writes only ever carry the channel 2 prefix
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && write_valid |->
			!success && error_code == ps2cre_pkg::ERR_NONE &&
			(!write_to_cmd_port || write_byte == ps2cre_pkg::BYTE_PREFIX_CH2))
		else $error("malformed write beat");

endmodule

bind ps2_device_command_retry_engine ps2cre_chk u_ps2cre_chk (.*);

FILE: verif/ps2_device_command_retry_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_device_command_retry_engine_test
// Self-checking bench for the PS/2 command retry engine. A directed table
// covers the extremes, the ignored items and each protocol corner: the
// self-test skip, resend, unrelated limit, both timeouts, timeout zero and
// attempt limit zero. Random exchanges steered by the local model's phase
// follow, under several configurations. Every accepted beat runs through a
// local model of the engine, and each result beat is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module ps2_device_command_retry_engine_test;

	localparam logic [1:0] OP_NOISE = 2'd3;   // unused operation, dropped by the block
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASE_ITEMS  = 125;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;
	logic       item_valid;
	logic       item_stall;
	logic [1:0] operation;
	logic [1:0] channel;
	logic [7:0] command;
	logic [7:0] rx_byte;
	logic       inbuf_full;
	logic       res_valid;
	logic       res_stall;
	logic       write_valid;
	logic       write_to_cmd_port;
	logic [7:0] write_byte;
	logic       done_res;
	logic       success;
	logic [7:0] answer;
	logic [1:0] error_code;

	ps2_device_command_retry_engine dut (.*);

	always #5 clk = ~clk;

	typedef struct {
		bit                  is_cfg;
		ps2cre_pkg::cfg_t    cfg;
		ps2cre_pkg::item_t   it;
		bit                  typed;
		bit                  has;
		ps2cre_pkg::result_t res;
	} step_row_t;

	step_row_t           directed_rows[$];
	ps2cre_pkg::result_t awaited_results[$];
	int                  mismatches = 0;
	int                  results_seen = 0;
	int                  cycles = 0;
	bit                  calm = 1'b0;
	bit                  hold_req = 1'b0;

	// local copy of the engine
	ps2cre_pkg::cfg_t eng_cfg;
	logic [2:0]       eng_phase;
	logic             eng_ch2;
	logic [7:0]       eng_cmd;
	logic [3:0]       eng_tries;
	logic [7:0]       eng_unrel;
	logic [9:0]       eng_wait;
	logic [7:0]       eng_answer;

	function automatic ps2cre_pkg::result_t wr_result(logic to_cmd, logic [7:0] b,
			logic [7:0] ans);
		ps2cre_pkg::result_t r;
		r = '0;
		r.write_valid = 1'b1;
		r.write_to_cmd_port = to_cmd;
		r.write_byte = b;
		r.answer = ans;
		return r;
	endfunction

	function automatic ps2cre_pkg::result_t done_result(logic ok, logic [7:0] ans,
			logic [1:0] err);
		ps2cre_pkg::result_t r;
		r = '0;
		r.done_res = 1'b1;
		r.success = ok;
		r.answer = ans;
		r.error_code = err;
		return r;
	endfunction

	function automatic bit close_exchange(logic ok, logic [1:0] err,
			output ps2cre_pkg::result_t r);
		r = done_result(ok, eng_answer, err);
		eng_phase = ps2cre_pkg::PH_IDLE;
		eng_wait = '0;
		return 1'b1;
	endfunction

	function automatic bit issue_write(output ps2cre_pkg::result_t r);
		if (eng_phase == ps2cre_pkg::PH_WR_PRE) begin
			r = wr_result(1'b1, ps2cre_pkg::BYTE_PREFIX_CH2, eng_answer);
			eng_phase = ps2cre_pkg::PH_WR_DATA;
		end else begin
			r = wr_result(1'b0, eng_cmd, eng_answer);
			eng_phase = ps2cre_pkg::PH_RD;
			eng_unrel = '0;
		end
		eng_wait = '0;
		return 1'b1;
	endfunction

	function automatic bit open_attempt(logic busy, output ps2cre_pkg::result_t r);
		eng_phase = eng_ch2 ? ps2cre_pkg::PH_WR_PRE : ps2cre_pkg::PH_WR_DATA;
		eng_wait = '0;
		if (!busy)
			return issue_write(r);
		if (eng_cfg.timeout_ticks == '0)
			return close_exchange(1'b0, ps2cre_pkg::ERR_WR_TO, r);
		return 1'b0;
	endfunction

	function automatic bit retry_command(logic busy, output ps2cre_pkg::result_t r);
		eng_tries = eng_tries + 4'd1;
		if (eng_tries >= eng_cfg.attempt_limit)
			return close_exchange(1'b0, ps2cre_pkg::ERR_ATTEMPT, r);
		return open_attempt(busy, r);
	endfunction

	function automatic bit judge_reply(logic [7:0] b, logic busy,
			output ps2cre_pkg::result_t r);
		if (b == ps2cre_pkg::BYTE_ACK || b == ps2cre_pkg::BYTE_ECHO)
			return close_exchange(1'b1, ps2cre_pkg::ERR_NONE, r);
		if (b == ps2cre_pkg::BYTE_RESEND)
			return retry_command(busy, r);
		eng_unrel = eng_unrel + 8'd1;
		if (eng_unrel == eng_cfg.unrelated_limit)
			return retry_command(busy, r);
		eng_phase = ps2cre_pkg::PH_RD;
		eng_wait = '0;
		return 1'b0;
	endfunction

	// Advance the local engine by one beat; returns 1 when a result is due.
	function automatic bit engine_step(ps2cre_pkg::item_t it, output ps2cre_pkg::result_t r);
		r = '0;
		case (it.operation)
			ps2cre_pkg::OP_START: begin
				if (eng_phase != ps2cre_pkg::PH_IDLE)
					return 1'b0;
				eng_ch2 = (it.channel == ps2cre_pkg::CHANNEL_TWO);
				eng_cmd = it.command;
				eng_tries = '0;
				eng_unrel = '0;
				eng_answer = '0;
				if (eng_cfg.attempt_limit == '0)
					return close_exchange(1'b0, ps2cre_pkg::ERR_ATTEMPT, r);
				return open_attempt(it.inbuf_full, r);
			end
			ps2cre_pkg::OP_BYTE: begin
				if (eng_phase == ps2cre_pkg::PH_RD) begin
					eng_answer = it.rx_byte;
					if (it.rx_byte == ps2cre_pkg::BYTE_SELF_TEST) begin
						eng_phase = ps2cre_pkg::PH_RD_AA;
						eng_wait = '0;
						return 1'b0;
					end
					return judge_reply(it.rx_byte, it.inbuf_full, r);
				end
				if (eng_phase == ps2cre_pkg::PH_RD_AA) begin
					eng_answer = it.rx_byte;
					return judge_reply(it.rx_byte, it.inbuf_full, r);
				end
				return 1'b0;
			end
			ps2cre_pkg::OP_TICK: begin
				if (eng_phase == ps2cre_pkg::PH_WR_PRE ||
				    eng_phase == ps2cre_pkg::PH_WR_DATA) begin
					eng_wait = eng_wait + 10'd1;
					if (!it.inbuf_full)
						return issue_write(r);
					if (eng_wait >= eng_cfg.timeout_ticks)
						return close_exchange(1'b0, ps2cre_pkg::ERR_WR_TO, r);
					return 1'b0;
				end
				if (eng_phase == ps2cre_pkg::PH_RD || eng_phase == ps2cre_pkg::PH_RD_AA) begin
					eng_wait = eng_wait + 10'd1;
					if (eng_wait >= eng_cfg.timeout_ticks)
						return close_exchange(1'b0, ps2cre_pkg::ERR_RD_TO, r);
				end
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Random beat shaped by where the exchange stands, with some noise.
	function automatic ps2cre_pkg::item_t pick_item();
		ps2cre_pkg::item_t it;
		int                r;
		it.operation = ps2cre_pkg::OP_TICK;
		it.channel = 2'($urandom_range(1, 2));
		it.command = 8'($urandom);
		it.rx_byte = 8'($urandom);
		it.inbuf_full = ($urandom_range(99) < 25);
		r = $urandom_range(99);
		if (r < 5) begin
			it.operation = 2'($urandom_range(3));
			it.channel = 2'($urandom_range(3));
			return it;
		end
		case (eng_phase)
			ps2cre_pkg::PH_IDLE: it.operation = ps2cre_pkg::OP_START;
			ps2cre_pkg::PH_WR_PRE, ps2cre_pkg::PH_WR_DATA:
				it.operation = (r < 12) ? ps2cre_pkg::OP_BYTE : ps2cre_pkg::OP_TICK;
			default: begin
				it.operation = (r < 18) ? ps2cre_pkg::OP_TICK : ps2cre_pkg::OP_BYTE;
				r = $urandom_range(99);
				if (r < 10)
					it.rx_byte = ps2cre_pkg::BYTE_SELF_TEST;
				else if (r < 40)
					it.rx_byte = r[0] ? ps2cre_pkg::BYTE_ACK : ps2cre_pkg::BYTE_ECHO;
				else if (r < 55)
					it.rx_byte = ps2cre_pkg::BYTE_RESEND;
			end
		endcase
		return it;
	endfunction

	function automatic void add_row(logic [1:0] op, logic [1:0] ch, logic [7:0] cmd,
			logic [7:0] b, logic busy, bit typed = 1'b0, bit has = 1'b0,
			ps2cre_pkg::result_t res = '0);
		step_row_t row;
		row.is_cfg = 1'b0;
		row.cfg = '0;
		row.it = '{op, ch, cmd, b, busy};
		row.typed = typed;
		row.has = has;
		row.res = res;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_cfg(logic [3:0] attempts, logic [7:0] unrel, logic [9:0] ticks);
		step_row_t row;
		row.is_cfg = 1'b1;
		row.cfg = '{attempts, unrel, ticks};
		row.it = '0;
		row.typed = 1'b0;
		row.has = 1'b0;
		row.res = '0;
		directed_rows.push_back(row);
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] result %0d: %s", $realtime, results_seen, msg);
	endtask

	task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	// Offer one beat and hold it until taken; predict on the accepting edge.
	task automatic send_item(ps2cre_pkg::item_t it, bit typed = 1'b0, bit has = 1'b0,
			ps2cre_pkg::result_t res = '0);
		ps2cre_pkg::result_t r;
		bit                  due;
		operation <= it.operation;
		channel <= it.channel;
		command <= it.command;
		rx_byte <= it.rx_byte;
		inbuf_full <= it.inbuf_full;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall !== 1'b0);
		due = engine_step(it, r);
		if (typed) begin
			due = has;
			r = res;
		end
		if (due)
			awaited_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(99) < 7) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// Drop valid and wait until every predicted result is back and the pipe is quiet.
	task automatic settle();
		item_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_config(ps2cre_pkg::cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= ps2cre_pkg::REG_ATTEMPT_LIMIT;
		cfg_data <= {6'd0, c.attempt_limit};
		@(negedge clk);
		cfg_index <= ps2cre_pkg::REG_UNRELATED_LIMIT;
		cfg_data <= {2'd0, c.unrelated_limit};
		@(negedge clk);
		cfg_index <= ps2cre_pkg::REG_TIMEOUT_TICKS;
		cfg_data <= c.timeout_ticks;
		@(negedge clk);
		cfg_we <= 1'b0;
		eng_cfg = c;
	endtask

	// result checker
	always @(posedge clk) begin
		ps2cre_pkg::result_t got;
		ps2cre_pkg::result_t want;
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
			results_seen++;
			got = {write_valid, write_to_cmd_port, write_byte, done_res, success,
				answer, error_code};
			if (awaited_results.size() == 0) begin
				report_mismatch("result beat with nothing awaited");
			end else begin
				want = awaited_results.pop_front();
				compare_field("write_valid", 8'(got.write_valid), 8'(want.write_valid));
				compare_field("write_to_cmd_port", 8'(got.write_to_cmd_port),
					8'(want.write_to_cmd_port));
				compare_field("write_byte", got.write_byte, want.write_byte);
				compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
				compare_field("success", 8'(got.success), 8'(want.success));
				compare_field("answer", got.answer, want.answer);
				compare_field("error_code", 8'(got.error_code), 8'(want.error_code));
			end
		end
	end

	// receiver: random stall, with one long hold-off on request
	always @(negedge clk) begin
		int hold_left;
		bit hold_done;
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= !calm && ($urandom_range(99) < 7);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("ps2_device_command_retry_engine: mismatch");
			$finish;
		end
	end

	initial begin
		ps2cre_pkg::cfg_t phase_cfg[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_valid = 1'b0;
		operation = ps2cre_pkg::OP_TICK;
		channel = '0;
		command = '0;
		rx_byte = '0;
		inbuf_full = 1'b0;
		eng_cfg = '{4'd5, 8'd100, 10'd100};
		eng_phase = ps2cre_pkg::PH_IDLE;
		eng_ch2 = 1'b0;
		eng_cmd = '0;
		eng_tries = '0;
		eng_unrel = '0;
		eng_wait = '0;
		eng_answer = '0;

		// stray beats while idle, then a plain exchange with the self-test skip
		add_row(ps2cre_pkg::OP_TICK, 2'd1, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_BYTE, 2'd1, 8'h00, 8'hFA, 1'b0, 1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_START, 2'd1, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b1,
			wr_result(1'b0, 8'hFF, 8'h00));
		add_row(ps2cre_pkg::OP_BYTE, 2'd1, 8'h00, ps2cre_pkg::BYTE_SELF_TEST, 1'b0,
			1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_BYTE, 2'd1, 8'h00, ps2cre_pkg::BYTE_ACK, 1'b0, 1'b1, 1'b1,
			done_result(1'b1, ps2cre_pkg::BYTE_ACK, ps2cre_pkg::ERR_NONE));
		// channel two behind a busy buffer, start while busy, resend
		add_row(ps2cre_pkg::OP_START, ps2cre_pkg::CHANNEL_TWO, 8'h00, 8'h00, 1'b1,
			1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_TICK, 2'd0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
			wr_result(1'b1, ps2cre_pkg::BYTE_PREFIX_CH2, 8'h00));
		add_row(ps2cre_pkg::OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
			wr_result(1'b0, 8'h00, 8'h00));
		add_row(ps2cre_pkg::OP_START, ps2cre_pkg::CHANNEL_TWO, 8'h77, 8'h00, 1'b0,
			1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_BYTE, 2'd0, 8'h00, ps2cre_pkg::BYTE_RESEND, 1'b0);
		add_row(ps2cre_pkg::OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0);
		add_row(ps2cre_pkg::OP_BYTE, 2'd0, 8'h00, ps2cre_pkg::BYTE_ECHO, 1'b0, 1'b1, 1'b1,
			done_result(1'b1, ps2cre_pkg::BYTE_ECHO, ps2cre_pkg::ERR_NONE));
		// timeout zero, unrelated limit reached on the last attempt
		add_cfg(4'd1, 8'd2, 10'd0);
		add_row(ps2cre_pkg::OP_START, 2'd1, 8'h5A, 8'h00, 1'b1, 1'b1, 1'b1,
			done_result(1'b0, 8'h00, ps2cre_pkg::ERR_WR_TO));
		add_row(ps2cre_pkg::OP_START, 2'd1, 8'h5A, 8'h00, 1'b0, 1'b1, 1'b1,
			wr_result(1'b0, 8'h5A, 8'h00));
		add_row(ps2cre_pkg::OP_TICK, 2'd1, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
			done_result(1'b0, 8'h00, ps2cre_pkg::ERR_RD_TO));
		add_row(ps2cre_pkg::OP_START, 2'd3, 8'h81, 8'h00, 1'b0, 1'b1, 1'b1,
			wr_result(1'b0, 8'h81, 8'h00));
		add_row(ps2cre_pkg::OP_BYTE, 2'd0, 8'h00, 8'h12, 1'b0, 1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_BYTE, 2'd0, 8'h00, 8'h34, 1'b0, 1'b1, 1'b1,
			done_result(1'b0, 8'h34, ps2cre_pkg::ERR_ATTEMPT));
		// attempt limit zero, then unrelated limit zero with the widest limits
		add_cfg(4'd0, 8'd0, 10'd1023);
		add_row(ps2cre_pkg::OP_START, ps2cre_pkg::CHANNEL_TWO, 8'hC3, 8'h00, 1'b0,
			1'b1, 1'b1, done_result(1'b0, 8'h00, ps2cre_pkg::ERR_ATTEMPT));
		add_cfg(4'd15, 8'd0, 10'd1023);
		add_row(ps2cre_pkg::OP_START, 2'd0, 8'h3C, 8'h00, 1'b0);
		add_row(ps2cre_pkg::OP_BYTE, 2'd0, 8'h00, ps2cre_pkg::BYTE_RESEND, 1'b1);
		add_row(ps2cre_pkg::OP_TICK, 2'd0, 8'h00, 8'h00, 1'b0);
		add_row(OP_NOISE, 2'd3, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
		add_row(ps2cre_pkg::OP_BYTE, 2'd0, 8'h00, 8'h00, 1'b0);

		phase_cfg[0] = '{4'd5, 8'd100, 10'd100};
		phase_cfg[1] = '{4'd1, 8'd1, 10'd1};
		phase_cfg[2] = '{4'd15, 8'd255, 10'd1023};
		phase_cfg[3] = '{4'd2, 8'd0, 10'd0};
		phase_cfg[4] = '{4'($urandom_range(1, 15)), 8'($urandom_range(1, 6)),
			10'($urandom_range(0, 12))};
		phase_cfg[5] = '{4'($urandom_range(15)), 8'($urandom_range(255)),
			10'($urandom_range(1023))};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle();
				load_config(directed_rows[i].cfg);
			end else begin
				maybe_idle();
				send_item(directed_rows[i].it, directed_rows[i].typed,
					directed_rows[i].has, directed_rows[i].res);
			end
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			load_config(phase_cfg[p]);
			calm = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1 && n == 40)
					hold_req = 1'b1;
				if (p == 4 && n == 60)
					settle();
				maybe_idle();
				send_item(pick_item());
			end
		end
		settle();

		if (mismatches == 0)
			$display("ps2_device_command_retry_engine: match");
		else
			$display("ps2_device_command_retry_engine: mismatch");
		$finish;
	end

endmodule
